### rtl/dss_pkg.sv
// ----------------------------------------------------------------------------
// Drum step sequencer package
// Shared defaults, widths, register indexes, action codes and control state type.
// ----------------------------------------------------------------------------
package dss_pkg;

    localparam int DEFAULT_INSTRUMENTS = 8;
    localparam int DEFAULT_STEPS       = 16;

    localparam int SPACING_W = 24;
    localparam int BUDGET_W  = 16;
    localparam int STEP_W    = 6;
    localparam int COLUMN_W  = 8;
    localparam int INSTR_W   = 4;

    // configuration register indexes
    localparam logic REG_LONG_STEP  = 1'b0;
    localparam logic REG_SHORT_STEP = 1'b1;

    // input action codes
    localparam logic ACT_TOGGLE  = 1'b0;
    localparam logic ACT_ADVANCE = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

endpackage

### rtl/dss_pattern_ram.sv
// ----------------------------------------------------------------------------
// Pattern memory
// One column of trigger bits per step, two registered read ports and one
// write port. Per-entry valid bits make unwritten entries read as zero.
// ----------------------------------------------------------------------------
module dss_pattern_ram import dss_pkg::*; #(
    parameter int DEPTH = DEFAULT_STEPS,
    parameter int WIDTH = DEFAULT_INSTRUMENTS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_b,
    output logic [WIDTH-1:0]         o_rd_data_a,
    output logic [WIDTH-1:0]         o_rd_data_b,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [WIDTH-1:0] r_data_a;
    logic [WIDTH-1:0] r_data_b;
    logic             r_vld_a;
    logic             r_vld_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_data_a <= mem[i_rd_addr_a];
            r_data_b <= mem[i_rd_addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_vld_a <= r_vld[i_rd_addr_a];
                r_vld_b <= r_vld[i_rd_addr_b];
            end
        end
    end

    // an entry never written since reset reads as an empty column
    assign o_rd_data_a = r_vld_a ? r_data_a : '0;
    assign o_rd_data_b = r_vld_b ? r_data_b : '0;

endmodule

### rtl/drum_step_sequencer_core.sv
// ----------------------------------------------------------------------------
// Drum step sequencer core
// Timing: start is taken into the EXEC state, and the result strobe is
// registered from EXEC. Throughput is set by the pattern memory read
// followed by its write-back; a new start may be taken in the strobe cycle.
// Reset (synchronous, active low) clears step, countdown, spacing registers
// and the pattern valid bits at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module drum_step_sequencer_core import dss_pkg::*; #(
    parameter int INSTRUMENTS = DEFAULT_INSTRUMENTS,
    parameter int STEPS       = DEFAULT_STEPS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [SPACING_W-1:0] i_cfg_data,
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_action,
    input  logic [INSTR_W-1:0]   i_instrument,
    input  logic [STEP_W-1:0]    i_step_index,
    input  logic [BUDGET_W-1:0]  i_sample_budget,
    output logic                 o_result_strobe,
    output logic [BUDGET_W-1:0]  o_samples_to_generate,
    output logic                 o_step_advanced,
    output logic [STEP_W-1:0]    o_playback_step,
    output logic [COLUMN_W-1:0]  o_step_column
);

    localparam int SW = $clog2(STEPS);
    localparam int CW = (INSTRUMENTS > COLUMN_W) ? INSTRUMENTS : COLUMN_W;

    t_state r_state, n_state;
    logic   w_accept;
    logic   w_exec;

    logic [SPACING_W-1:0] r_long, r_short;
    logic [SPACING_W-1:0] r_count, n_count;
    logic [SW-1:0]        r_step, n_step;
    logic [SW-1:0]        w_step_inc;
    logic                 w_count_ge;
    logic                 w_adv;
    logic [BUDGET_W-1:0]  r_gen, n_gen;
    logic                 r_adv;

    logic                   w_tgl_en;
    logic [INSTRUMENTS-1:0] w_bit_oh, w_partner_oh;
    logic                   r_tgl_en;
    logic [SW-1:0]          r_tgl_step;
    logic [INSTRUMENTS-1:0] r_bit_oh, r_partner_oh;

    logic [INSTRUMENTS-1:0] w_rd_a, w_rd_b;
    logic [INSTRUMENTS-1:0] w_new_col, w_col_out;
    logic [CW-1:0]          w_col_ext;

    logic                 r_strobe;
    logic [BUDGET_W-1:0]  r_out_gen;
    logic                 r_out_adv;
    logic [STEP_W-1:0]    r_out_step;
    logic [COLUMN_W-1:0]  r_out_col;

    // ---- control ----
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (start) n_state = ST_EXEC;
            ST_EXEC: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_exec = 1'b0;
        case (r_state)
            ST_IDLE: w_exec = 1'b0;
            ST_EXEC: w_exec = 1'b1;
            default: w_exec = 1'b0;
        endcase
    end

    assign busy     = w_exec || !i_rst_n;
    assign w_accept = start && (r_state == ST_IDLE);

    // ---- advance: spend the budget against the countdown ----
    assign w_count_ge = r_count >= SPACING_W'(i_sample_budget);
    assign w_adv      = (i_action == ACT_ADVANCE) && !w_count_ge;
    assign w_step_inc = (r_step == SW'(STEPS - 1)) ? '0 : r_step + 1'b1;

    always_comb begin
        n_step  = r_step;
        n_count = r_count;
        n_gen   = '0;
        if (i_action == ACT_ADVANCE) begin
            if (w_count_ge) begin
                n_count = r_count - SPACING_W'(i_sample_budget);
                n_gen   = i_sample_budget;
            end else begin
                // countdown is below a 16-bit budget here, so it fits
                n_gen   = r_count[BUDGET_W-1:0];
                n_step  = w_step_inc;
                n_count = w_step_inc[0] ? r_short : r_long;
            end
        end
    end

    // ---- toggle decode ----
    assign w_tgl_en = (i_action == ACT_TOGGLE)
                   && (32'(i_instrument) < INSTRUMENTS)
                   && (32'(i_step_index) < STEPS);

    always_comb begin
        for (int k = 0; k < INSTRUMENTS; k++) begin
            w_bit_oh[k]     = (32'(i_instrument) == k);
            // 2 pairs with 3, 4 pairs with 5
            w_partner_oh[k] = (i_instrument inside {[4'd2:4'd5]})
                           && (32'(i_instrument ^ 4'd1) == k);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_long  <= '0;
            r_short <= '0;
            r_step  <= '0;
            r_count <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= w_exec;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_LONG_STEP:  r_long  <= i_cfg_data;
                    REG_SHORT_STEP: r_short <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_accept) begin
                r_step  <= n_step;
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_gen        <= n_gen;
            r_adv        <= w_adv;
            r_tgl_en     <= w_tgl_en;
            r_tgl_step   <= i_step_index[SW-1:0];
            r_bit_oh     <= w_bit_oh;
            r_partner_oh <= w_partner_oh;
        end
        if (w_exec) begin
            r_out_gen  <= r_gen;
            r_out_adv  <= r_adv;
            r_out_step <= STEP_W'(r_step);
            r_out_col  <= w_col_ext[COLUMN_W-1:0];
        end
    end

    // ---- pattern memory: read on transfer, modify and write back in EXEC ----
    dss_pattern_ram #(
        .DEPTH (STEPS),
        .WIDTH (INSTRUMENTS)
    ) u_ram (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (w_accept),
        .i_rd_addr_a (i_step_index[SW-1:0]),
        .i_rd_addr_b (n_step),
        .o_rd_data_a (w_rd_a),
        .o_rd_data_b (w_rd_b),
        .i_wr_en     (w_exec && r_tgl_en),
        .i_wr_addr   (r_tgl_step),
        .i_wr_data   (w_new_col)
    );

    // set drops the partner, clear leaves it
    assign w_new_col = ((w_rd_a & r_bit_oh) != '0) ? (w_rd_a & ~r_bit_oh)
                                                   : ((w_rd_a | r_bit_oh) & ~r_partner_oh);

    // forward the fresh column when the toggle hits the playback step
    assign w_col_out = (r_tgl_en && (r_tgl_step == r_step)) ? w_new_col : w_rd_b;
    assign w_col_ext = CW'(w_col_out);

    assign o_result_strobe       = r_strobe;
    assign o_samples_to_generate = r_out_gen;
    assign o_step_advanced       = r_out_adv;
    assign o_playback_step       = r_out_step;
    assign o_step_column         = r_out_col;

endmodule

### rtl/dss_checker.sv
// ----------------------------------------------------------------------------
// Drum step sequencer checker
// Port-level timing and result checks, bound to the core.
// ----------------------------------------------------------------------------
module dss_props import dss_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input logic                i_action,
    input logic                o_result_strobe,
    input logic [BUDGET_W-1:0] o_samples_to_generate,
    input logic                o_step_advanced
);

    // every transfer yields exactly one strobe, which follows its EXEC cycle
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_result_strobe)
        else $error("result strobe missing two cycles after transfer");

    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> $past(busy))
        else $error("result strobe without a busy cycle before it");

    a_busy_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy)
        else $error("busy held longer than one cycle");

    a_toggle_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_action == ACT_TOGGLE)) |=> ##1
            ((o_samples_to_generate == '0) && !o_step_advanced))
        else $error("toggle result reports samples or a step advance");

endmodule

bind drum_step_sequencer_core dss_props u_dss_props (.*);
